FILE: design/walc_pkg.sv
package walc_pkg;

  typedef enum logic [2:0] {
    KIND_GRANTED = 3'd0,
    KIND_WAIT    = 3'd1,
    KIND_ABSORB  = 3'd2,
    KIND_PIN     = 3'd3,
    KIND_COPY    = 3'd4,
    KIND_HEADER  = 3'd5,
    KIND_DONE    = 3'd6,
    KIND_ERROR   = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_END   = 2'd1,
    OP_WRITE = 2'd2,
    OP_BAD   = 2'd3
  } op_t;

  localparam logic CFG_IDX_START = 1'b0;
  localparam logic CFG_IDX_AREA  = 1'b1;

  // classified word handed from front to back
  typedef struct packed {
    op_t         op;
    logic [31:0] blk;
  } cmd_t;

endpackage

FILE: design/walc_ram.sv
module walc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: design/walc_front.sv
// Front: takes start words into a two-entry queue.
module walc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  walc_pkg::cmd_t    push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              avail,
  output walc_pkg::cmd_t    head
);
  walc_pkg::cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;

  assign full  = (cnt_r == 2'd2);
  assign avail = (cnt_r != 2'd0);
  assign head  = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= push_cmd;
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
    end
  end
endmodule

FILE: design/walc_back.sv
// Back: carries out one word at a time against the block list.
module walc_back #(
  parameter int LOG_CAPACITY     = 30,
  parameter int OP_BLOCK_RESERVE = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                avail,
  input  walc_pkg::cmd_t      head,
  output logic                pop,
  input  logic [31:0]         log_start_block,
  input  logic [15:0]         log_area_blocks,
  output logic                out_valid,
  output logic [2:0]          out_kind,
  output logic [31:0]         out_source_block,
  output logic [31:0]         out_dest_block,
  output logic [4:0]          out_header_count,
  output logic                out_unpin,
  output logic                out_last
);
  localparam int AW = $clog2(LOG_CAPACITY);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_CMP    = 6'b000100,
    S_COPY1  = 6'b001000,
    S_COPY2  = 6'b010000,
    S_HDR2   = 6'b100000
  } state_t;

  state_t      st_r, st_nxt;
  logic [4:0]  cnt_r, open_r;
  logic [4:0]  idx_r;
  logic [31:0] blk_r;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] rdata;

  walc_ram #(.WIDTH(32), .DEPTH(LOG_CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(blk_r), .raddr(raddr), .rdata(rdata)
  );

  assign raddr = idx_r[AW-1:0];
  assign waddr = cnt_r[AW-1:0];

  // begin check and misuse checks
  logic [9:0] need;
  logic       wr_bad;
  assign need = {5'd0, cnt_r} + ({5'd0, open_r} + 10'd1) * 10'(OP_BLOCK_RESERVE);
  assign wr_bad = (open_r == 5'd0) || ({27'd0, cnt_r} >= 32'(LOG_CAPACITY)) ||
                  ({11'd0, cnt_r} + 16'd1 >= log_area_blocks);

  always_comb begin
    st_nxt = st_r;
    pop = 1'b0;
    we = 1'b0;
    out_valid = 1'b0;
    out_kind = walc_pkg::KIND_DONE;
    out_source_block = '0;
    out_dest_block = '0;
    out_header_count = '0;
    out_unpin = 1'b0;
    out_last = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (avail) begin
          pop = 1'b1;
          unique case (head.op)
            walc_pkg::OP_BEGIN: begin
              out_valid = 1'b1; out_last = 1'b1;
              out_kind = (need > 10'(LOG_CAPACITY)) ? walc_pkg::KIND_WAIT
                                                   : walc_pkg::KIND_GRANTED;
            end
            walc_pkg::OP_WRITE: begin
              if (wr_bad) begin
                out_valid = 1'b1; out_last = 1'b1; out_kind = walc_pkg::KIND_ERROR;
              end else begin
                st_nxt = S_SEARCH;
              end
            end
            walc_pkg::OP_END: begin
              if (open_r == 5'd0) begin
                out_valid = 1'b1; out_last = 1'b1; out_kind = walc_pkg::KIND_ERROR;
              end else if (open_r != 5'd1 || cnt_r == 5'd0) begin
                out_valid = 1'b1; out_last = 1'b1; out_kind = walc_pkg::KIND_DONE;
              end else begin
                st_nxt = S_COPY1;
              end
            end
            default: begin
              out_valid = 1'b1; out_last = 1'b1; out_kind = walc_pkg::KIND_ERROR;
            end
          endcase
        end
      end
      // idx_r issues a read; compare arrives next cycle
      S_SEARCH: begin
        if (idx_r == cnt_r) begin
          we = 1'b1;
          out_valid = 1'b1; out_last = 1'b1; out_kind = walc_pkg::KIND_PIN;
          st_nxt = S_IDLE;
        end else begin
          st_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (rdata == blk_r) begin
          out_valid = 1'b1; out_last = 1'b1; out_kind = walc_pkg::KIND_ABSORB;
          st_nxt = S_IDLE;
        end else begin
          st_nxt = S_SEARCH;
        end
      end
      // data read at idx_r-1 shows with idx_r, so its slot is
      // start+1+(idx_r-1) = start+idx_r
      S_COPY1: begin
        if (idx_r != 5'd0) begin
          out_valid = 1'b1; out_kind = walc_pkg::KIND_COPY;
          out_source_block = rdata;
          out_dest_block = log_start_block + {27'd0, idx_r};
        end
        if (idx_r == cnt_r) begin
          st_nxt = S_COPY2;
        end
      end
      S_COPY2: begin
        out_valid = 1'b1;
        if (idx_r == 5'd0) begin
          out_kind = walc_pkg::KIND_HEADER;
          out_dest_block = log_start_block;
          out_header_count = cnt_r;
        end else begin
          out_kind = walc_pkg::KIND_COPY;
          out_source_block = log_start_block + {27'd0, idx_r};
          out_dest_block = rdata;
          out_unpin = 1'b1;
        end
        if (idx_r == cnt_r) st_nxt = S_HDR2;
      end
      S_HDR2: begin
        out_valid = 1'b1; out_last = 1'b1;
        out_kind = walc_pkg::KIND_HEADER;
        out_dest_block = log_start_block;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // index counter: in copy phases, register idx as "count emitted", read addr = idx
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && avail) blk_r <= head.blk;
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= 5'd0;
      open_r <= 5'd0;
      idx_r <= 5'd0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        S_IDLE: begin
          idx_r <= 5'd0;
          if (avail && head.op == walc_pkg::OP_BEGIN && !(need > 10'(LOG_CAPACITY)))
            open_r <= open_r + 5'd1;
          if (avail && head.op == walc_pkg::OP_END && open_r != 5'd0)
            open_r <= open_r - 5'd1;
        end
        S_SEARCH: if (idx_r == cnt_r) cnt_r <= cnt_r + 5'd1;
        S_CMP: idx_r <= idx_r + 5'd1;
        S_COPY1: idx_r <= (idx_r == cnt_r) ? 5'd0 : idx_r + 5'd1;
        S_COPY2: if (idx_r != cnt_r) idx_r <= idx_r + 5'd1;
        S_HDR2: cnt_r <= 5'd0;
        default: ;
      endcase
    end
  end
endmodule

FILE: design/write_ahead_log_controller_core.sv
// Transaction log controller with group commit. A command word is taken
// when start is high and busy is low; results appear on out_* for one cycle
// each, marked by out_valid, with out_last on the final one, and cannot be
// stalled. With the back end idle, a begin, an end that does not commit and
// a refused word answer in the cycle after they are taken. A write walks the
// block list entry by entry (list memory with registered read) and answers
// absorb on a hit, or pin after appending the block to the list. The commit
// after the last end gives its 2n+2 results, for a list of n entries, one
// per cycle. A two-word queue sits in front, so busy rises only while two
// words wait behind the one the back end is working on.
module write_ahead_log_controller_core #(
  parameter int LOG_CAPACITY     = 30,
  parameter int OP_BLOCK_RESERVE = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_block_number,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic [2:0]  out_kind,
  output logic [31:0] out_source_block,
  output logic [31:0] out_dest_block,
  output logic [4:0]  out_header_count,
  output logic        out_unpin,
  output logic        out_last
);
  logic [31:0] start_blk_r;
  logic [15:0] area_r;
  logic        avail, pop, full;
  walc_pkg::cmd_t head, push_cmd;

  assign cfg_ready = 1'b1;
  assign busy = full;
  assign push_cmd.op = walc_pkg::op_t'(in_opcode);
  assign push_cmd.blk = in_block_number;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_blk_r <= 32'd2;
      area_r <= 16'd31;
    end else if (cfg_valid) begin
      if (cfg_index == walc_pkg::CFG_IDX_START) start_blk_r <= cfg_data;
      else area_r <= cfg_data[15:0];
    end
  end

  walc_front u_front (
    .clk(clk), .rst_n(rst_n), .push(start && !full), .push_cmd(push_cmd),
    .full(full), .pop(pop), .avail(avail), .head(head)
  );

  walc_back #(.LOG_CAPACITY(LOG_CAPACITY), .OP_BLOCK_RESERVE(OP_BLOCK_RESERVE)) u_back (
    .clk(clk), .rst_n(rst_n), .avail(avail), .head(head), .pop(pop),
    .log_start_block(start_blk_r), .log_area_blocks(area_r),
    .out_valid(out_valid), .out_kind(out_kind), .out_source_block(out_source_block),
    .out_dest_block(out_dest_block), .out_header_count(out_header_count),
    .out_unpin(out_unpin), .out_last(out_last)
  );
endmodule
